// ===== hdl/lis_pkg.sv =====
package lis_pkg;

  localparam int CHANS     = 4;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 9;
  localparam int STEP_W    = 24;
  localparam int CH_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int POS_W     = 32;
  localparam int ACC_W     = 48;
  localparam int WT_W      = 16;
  localparam int PROD_W    = 32;
  localparam int Q_BITS    = 9;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_STEP_X     = 3'd4,
    REG_STEP_Y     = 3'd5,
    REG_CHANNELS   = 3'd6
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  // Shift-and-subtract quotient, evaluated only while the kernel table is built.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    logic [64:0]     r;
    longint unsigned q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic smag_t sin_pi_mag(longint unsigned n, longint unsigned den);
    longint unsigned k, f, g, x, x2, t;
    smag_t r;
    k = udiv(n, den);
    f = n - k * den;
    g = (2 * f <= den) ? f : den - f;
    x = udiv(PI_Q30 * g, den);
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    t = ONE_Q30 - udiv((x2 * t) >> 30, 64'd72);
    t = ONE_Q30 - udiv((x2 * t) >> 30, 64'd42);
    t = ONE_Q30 - udiv((x2 * t) >> 30, 64'd20);
    t = ONE_Q30 - udiv((x2 * t) >> 30, 64'd6);
    r.neg = k[0];
    r.mag = (x * t) >> 30;
    return r;
  endfunction

  function automatic smag_t sinc_mag(longint unsigned n, longint unsigned den);
    smag_t s;
    smag_t r;
    longint unsigned xf;
    r.neg = 1'b0;
    r.mag = ONE_Q30;
    if (n != 0) begin
      s = sin_pi_mag(n, den);
      r.neg = s.neg;
      xf = udiv(PI_Q30 * n, den);
      if (xf != 0) begin
        r.mag = udiv(s.mag << 30, xf);
      end
    end
    return r;
  endfunction

  function automatic logic signed [WT_W-1:0] lanczos_q14(longint unsigned p,
                                                        longint unsigned phases,
                                                        longint unsigned radius);
    smag_t a;
    smag_t b;
    longint unsigned m, q;
    logic signed [WT_W-1:0] w;
    w = '0;
    if (p < radius * phases) begin
      a = sinc_mag(p, phases);
      b = sinc_mag(p, phases * radius);
      m = (a.mag * b.mag) >> 30;
      q = (m + 64'd32768) >> 16;
      w = (a.neg != b.neg) ? -WT_W'(q) : WT_W'(q);
    end
    return w;
  endfunction

endpackage

// ===== hdl/lis_store.sv =====
module lis_store
  import lis_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [CHANS*PIX_W-1:0]  wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [CHANS*PIX_W-1:0]  rd_data
);

  logic [CHANS*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/lis_divider.sv =====
module lis_divider
  import lis_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  acc_t num [CHANS],
  input  acc_t den,
  output logic done,
  output pix_t quot [CHANS]
);

  localparam int CW = $clog2(Q_BITS + 1);

  acc_t             rem [CHANS];
  logic [Q_BITS-1:0] qb [CHANS];
  acc_t             dsh;
  logic [CW-1:0]    cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(Q_BITS);
        dsh  <= den <<< (Q_BITS - 1);
        for (int c = 0; c < CHANS; c++) begin
          rem[c] <= (num[c] > 0) ? num[c] : '0;
          qb[c]  <= '0;
        end
      end else if (busy) begin
        for (int c = 0; c < CHANS; c++) begin
          if (rem[c] >= dsh) begin
            rem[c] <= rem[c] - dsh;
            qb[c]  <= {qb[c][Q_BITS-2:0], 1'b1};
          end else begin
            qb[c]  <= {qb[c][Q_BITS-2:0], 1'b0};
          end
        end
        dsh <= dsh >>> 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      quot[c] = qb[c][Q_BITS-1] ? '1 : qb[c][PIX_W-1:0];
    end
  end

endmodule

// ===== hdl/lanczos_image_scaler.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_stall    action, pixel_x, pixel_y, chan0..chan3
// out      out_valid / out_stall  covered, range_error, out_chan0..out_chan3
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// A load item writes the image memory directly.
// A compute item presents its result after one image memory read per tap and a
// 9-step divider; the next item can be taken once that result is presented.
// Without a positive weight sum the divider is skipped; an out-of-range item
// goes straight to its result.
// Reset is synchronous; the image memory is not cleared.
// A waiting result does not block load items; a compute item ends only once
// the output register is free.
module lanczos_image_scaler
  import lis_pkg::*;
#(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int KERNEL_RADIUS = 2,
  parameter int TABLE_PHASES  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           pixel_x,
  input  logic [7:0]           pixel_y,
  input  logic [7:0]           chan0,
  input  logic [7:0]           chan1,
  input  logic [7:0]           chan2,
  input  logic [7:0]           chan3,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 covered,
  output logic                 range_error,
  output logic [7:0]           out_chan0,
  output logic [7:0]           out_chan1,
  output logic [7:0]           out_chan2,
  output logic [7:0]           out_chan3,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int TAPS   = 2 * KERNEL_RADIUS;
  localparam int TI_W   = $clog2(TAPS);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int KDEPTH = KERNEL_RADIUS * TABLE_PHASES;
  localparam int KI_W   = $clog2(KDEPTH);
  localparam int IX_W   = 18;
  localparam int D_W    = 40;

  typedef logic signed [WT_W-1:0] ktab_t [KDEPTH];

  function automatic ktab_t build_ktab();
    ktab_t t;
    for (int p = 0; p < KDEPTH; p++) begin
      t[p] = lanczos_q14(64'(p), 64'(TABLE_PHASES), 64'(KERNEL_RADIUS));
    end
    return t;
  endfunction

  localparam ktab_t KTAB = build_ktab();

  typedef enum logic [2:0] {S_IDLE, S_TAPS, S_RUN, S_DIV, S_DONE} state_t;

  state_t state;

  logic [DIM_W-1:0]  src_w, src_h, dst_w, dst_h;
  logic [STEP_W-1:0] step_x, step_y;
  logic [CH_W-1:0]   channels;

  logic [POS_W-1:0]  pos_x, pos_y;
  logic [TI_W-1:0]   ti, tj;
  logic              issuing;

  logic signed [WT_W-1:0] wxa [TAPS];
  logic signed [WT_W-1:0] wya [TAPS];
  logic                   xva [TAPS];
  logic                   yva [TAPS];
  logic [XW-1:0]          xaa [TAPS];
  logic [YW-1:0]          yaa [TAPS];

  logic res_cov, res_rng;

  logic in_acc;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w    <= DIM_W'(256);
      src_h    <= DIM_W'(256);
      dst_w    <= DIM_W'(256);
      dst_h    <= DIM_W'(256);
      step_x   <= STEP_W'(65536);
      step_y   <= STEP_W'(65536);
      channels <= CH_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w    <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h    <= cfg_data[DIM_W-1:0];
        REG_DST_WIDTH:  dst_w    <= cfg_data[DIM_W-1:0];
        REG_DST_HEIGHT: dst_h    <= cfg_data[DIM_W-1:0];
        REG_STEP_X:     step_x   <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:     step_y   <= cfg_data[STEP_W-1:0];
        REG_CHANNELS:   channels <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Tap geometry for the tap under the counter, both axes.
  logic [DIM_W-1:0]       sw, sh;
  logic signed [D_W-1:0]  dx, dy;
  logic [D_W-1:0]         adx, ady, phx, phy;
  logic signed [IX_W-1:0] xi, yi;
  logic signed [WT_W-1:0] wx_n, wy_n;
  logic                   xv_n, yv_n;

  always_comb begin
    sw = (32'(src_w) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : src_w;
    sh = (32'(src_h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : src_h;
    dx = $signed({24'd0, pos_x[15:0]}) + ($signed(D_W'(KERNEL_RADIUS - 1 - int'(ti))) <<< 16);
    dy = $signed({24'd0, pos_y[15:0]}) + ($signed(D_W'(KERNEL_RADIUS - 1 - int'(ti))) <<< 16);
    adx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ady = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    phx = (adx * D_W'(TABLE_PHASES) + D_W'(32768)) >> 16;
    phy = (ady * D_W'(TABLE_PHASES) + D_W'(32768)) >> 16;
    wx_n = (phx >= D_W'(KDEPTH)) ? '0 : KTAB[phx[KI_W-1:0]];
    wy_n = (phy >= D_W'(KDEPTH)) ? '0 : KTAB[phy[KI_W-1:0]];
    xi = $signed({2'b00, pos_x[31:16]}) - $signed(IX_W'(KERNEL_RADIUS - 1))
         + $signed(IX_W'(ti));
    yi = $signed({2'b00, pos_y[31:16]}) - $signed(IX_W'(KERNEL_RADIUS - 1))
         + $signed(IX_W'(ti));
    xv_n = !xi[IX_W-1] && (xi < $signed({9'd0, sw}));
    yv_n = !yi[IX_W-1] && (yi < $signed({9'd0, sh}));
  end

  // Image memory.
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   wr_en;
  logic [CHANS*PIX_W-1:0] rd_data;

  assign wr_en   = in_acc && !action && (32'(pixel_x) < MAX_WIDTH)
                   && (32'(pixel_y) < MAX_HEIGHT);
  assign wr_addr = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);
  assign rd_addr = AW'(yaa[tj]) * AW'(MAX_WIDTH) + AW'(xaa[ti]);

  lis_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({chan3, chan2, chan1, chan0}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Multiply-accumulate pipeline.
  logic                   s1_v, s2_v;
  logic signed [WT_W-1:0] s1_wx, s1_wy;
  logic signed [PROD_W-1:0] s2_w;
  logic [CHANS*PIX_W-1:0] s2_pix;
  acc_t                   acc [CHANS];
  acc_t                   wsum;
  logic                   comp_start;

  assign comp_start = in_acc && action;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v  <= issuing && xva[ti] && yva[tj];
      s1_wx <= wxa[ti];
      s1_wy <= wya[tj];
      s2_v  <= s1_v;
      s2_w  <= PROD_W'(s1_wx) * PROD_W'(s1_wy);
      s2_pix <= rd_data;
      if (comp_start) begin
        wsum <= '0;
        for (int c = 0; c < CHANS; c++) begin
          acc[c] <= '0;
        end
      end else if (s2_v) begin
        wsum <= wsum + ACC_W'(s2_w);
        for (int c = 0; c < CHANS; c++) begin
          acc[c] <= acc[c] + ACC_W'(s2_w) * ACC_W'($signed({1'b0, s2_pix[c*PIX_W +: PIX_W]}));
        end
      end
    end
  end

  logic div_start, div_done;
  pix_t quot [CHANS];

  lis_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (wsum),
    .done  (div_done),
    .quot  (quot)
  );

  logic [CH_W-1:0] nch;
  assign nch = (channels == '0) ? CH_W'(1) : ((channels > CH_W'(CHANS)) ? CH_W'(CHANS) : channels);
  assign div_start = (state == S_RUN) && !issuing && !s1_v && !s2_v && (wsum > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      ti        <= '0;
      tj        <= '0;
      res_cov   <= 1'b0;
      res_rng   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (comp_start) begin
            pos_x <= POS_W'(pixel_x) * POS_W'(step_x);
            pos_y <= POS_W'(pixel_y) * POS_W'(step_y);
            ti    <= '0;
            tj    <= '0;
            res_cov <= 1'b0;
            res_rng <= 1'b0;
            if ({1'b0, pixel_x} >= dst_w || {1'b0, pixel_y} >= dst_h) begin
              res_rng <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_TAPS;
            end
          end
        end
        S_TAPS: begin
          wxa[ti] <= wx_n;
          wya[ti] <= wy_n;
          xva[ti] <= xv_n;
          yva[ti] <= yv_n;
          xaa[ti] <= xi[XW-1:0];
          yaa[ti] <= yi[YW-1:0];
          if (ti == TI_W'(TAPS - 1)) begin
            ti      <= '0;
            issuing <= 1'b1;
            state   <= S_RUN;
          end else begin
            ti <= ti + TI_W'(1);
          end
        end
        S_RUN: begin
          if (issuing) begin
            if (ti == TI_W'(TAPS - 1)) begin
              ti <= '0;
              if (tj == TI_W'(TAPS - 1)) begin
                tj      <= '0;
                issuing <= 1'b0;
              end else begin
                tj <= tj + TI_W'(1);
              end
            end else begin
              ti <= ti + TI_W'(1);
            end
          end else if (!s1_v && !s2_v) begin
            state <= (wsum > 0) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_cov <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            covered     <= res_cov;
            range_error <= res_rng;
            out_chan0   <= (res_cov && nch > CH_W'(0)) ? quot[0] : '0;
            out_chan1   <= (res_cov && nch > CH_W'(1)) ? quot[1] : '0;
            out_chan2   <= (res_cov && nch > CH_W'(2)) ? quot[2] : '0;
            out_chan3   <= (res_cov && nch > CH_W'(3)) ? quot[3] : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cov_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(covered && range_error))
    else $error("covered and range_error both set");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_mac_state: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> state == S_RUN)
    else $error("accumulate outside the tap phase");

endmodule

// ===== tb/lanczos_image_scaler_tb.sv =====
module lanczos_image_scaler_tb;
  import lis_pkg::*;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned Q30_PI  = 64'd3373259426;
  localparam int PHASES = 64;
  localparam int RADIUS = 2;

  typedef struct packed {
    logic       act;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
  } pixel_req_t;

  typedef struct packed {
    logic       cov;
    logic       rerr;
    logic [7:0] o0;
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [7:0] pixel_x = '0, pixel_y = '0;
  logic [7:0] chan0 = '0, chan1 = '0, chan2 = '0, chan3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic covered, range_error;
  logic [7:0] out_chan0, out_chan1, out_chan2, out_chan3;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  lanczos_image_scaler dut (.*);

  pixel_req_t pending_q[$];
  pixel_res_t resampled_q[$];
  logic [31:0] image_copy[65536];
  bit written[65536];
  int kern_lut[2*PHASES];
  int unsigned sw_cfg, sh_cfg, dw_cfg, dh_cfg, stx_cfg, sty_cfg, nch_cfg;
  int send_idle = 0, recv_stall = 0;
  int holds_asked = 0, holds_seen = 0, hold_left = 0;
  bit in_took = 1'b0;
  int errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("lanczos_image_scaler_tb: FAIL");
    $finish;
  end

  function automatic longint unsigned sine_q30(longint unsigned n, longint unsigned den,
                                               output bit neg);
    longint unsigned k, f, g, x, x2, t;
    k = n / den;
    f = n % den;
    g = (2 * f <= den) ? f : den - f;
    x = Q30_PI * g / den;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    neg = k[0];
    return (x * t) >> 30;
  endfunction

  function automatic longint unsigned sinc_q30(longint unsigned n, longint unsigned den,
                                               output bit neg);
    longint unsigned s, xf;
    neg = 1'b0;
    if (n == 0) return Q30_ONE;
    s = sine_q30(n, den, neg);
    xf = Q30_PI * n / den;
    if (xf == 0) return Q30_ONE;
    return (s << 30) / xf;
  endfunction

  function automatic int kernel_q14(longint unsigned p);
    bit na, nb;
    longint unsigned a, b, m, q;
    if (p >= RADIUS * PHASES) return 0;
    a = sinc_q30(p, PHASES, na);
    b = sinc_q30(p, PHASES * RADIUS, nb);
    m = (a * b) >> 30;
    q = (m + 64'd32768) >> 16;
    return (na != nb) ? -int'(q) : int'(q);
  endfunction

  function automatic void axis_weights(longint pos, output longint idx[4], output int w[4]);
    longint f, d;
    longint unsigned p;
    f = pos >>> 16;
    for (int i = 0; i < 4; i++) begin
      idx[i] = f - RADIUS + 1 + i;
      d = pos - idx[i] * 65536;
      if (d < 0) d = -d;
      p = (longint'(d) * PHASES + 32768) >> 16;
      w[i] = (p >= RADIUS * PHASES) ? 0 : kern_lut[p];
    end
  endfunction

  function automatic pixel_res_t resample(pixel_req_t r);
    pixel_res_t res;
    longint xi[4], yi[4];
    int wx[4], wy[4];
    longint acc[4], wsum, w, q, sw, sh;
    int nch;
    logic [31:0] pix;
    logic [7:0] ch[4];
    res = '0;
    if (r.x >= dw_cfg || r.y >= dh_cfg) begin
      res.rerr = 1'b1;
      return res;
    end
    sw = sw_cfg > 256 ? 256 : sw_cfg;
    sh = sh_cfg > 256 ? 256 : sh_cfg;
    nch = nch_cfg == 0 ? 1 : (nch_cfg > 4 ? 4 : nch_cfg);
    axis_weights(longint'(r.x) * stx_cfg, xi, wx);
    axis_weights(longint'(r.y) * sty_cfg, yi, wy);
    acc = '{0, 0, 0, 0};
    wsum = 0;
    for (int j = 0; j < 4; j++) begin
      if (yi[j] < 0 || yi[j] >= sh) continue;
      for (int i = 0; i < 4; i++) begin
        if (xi[i] < 0 || xi[i] >= sw) continue;
        pix = image_copy[yi[j] * 256 + xi[i]];
        w = longint'(wx[i]) * wy[j];
        for (int c = 0; c < 4; c++) acc[c] += w * longint'(pix[8*c +: 8]);
        wsum += w;
      end
    end
    if (wsum <= 0) return res;
    res.cov = 1'b1;
    for (int c = 0; c < 4; c++) begin
      q = 0;
      if (c < nch && acc[c] > 0) begin
        q = acc[c] / wsum;
        if (q > 255) q = 255;
      end
      ch[c] = q[7:0];
    end
    res.o0 = ch[0];
    res.o1 = ch[1];
    res.o2 = ch[2];
    res.o3 = ch[3];
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_req_t r;
    pixel_res_t got, want;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      r = '{action, pixel_x, pixel_y, chan0, chan1, chan2, chan3};
      if (!r.act) begin
        image_copy[{r.y, r.x}] = {r.c3, r.c2, r.c1, r.c0};
        written[{r.y, r.x}] = 1'b1;
      end else begin
        resampled_q.push_back(resample(r));
      end
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{covered, range_error, out_chan0, out_chan1, out_chan2, out_chan3};
      if (resampled_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = resampled_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected cov=%b rerr=%b ch=%h %h %h %h", $time,
                   want.cov, want.rerr, want.o0, want.o1, want.o2, want.o3);
          $display("%0t:          actual   cov=%b rerr=%b ch=%h %h %h %h", $time,
                   got.cov, got.rerr, got.o0, got.o1, got.o2, got.o3);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    pixel_req_t r;
    if (!rst && (!in_valid || in_took)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        r = pending_q.pop_front();
        action <= r.act;
        pixel_x <= r.x;
        pixel_y <= r.y;
        chan0 <= r.c0;
        chan1 <= r.c1;
        chan2 <= r.c2;
        chan3 <= r.c3;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holds_asked > holds_seen) begin
      holds_seen++;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DAT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SRC_WIDTH:  sw_cfg = v & 'h1FF;
      REG_SRC_HEIGHT: sh_cfg = v & 'h1FF;
      REG_DST_WIDTH:  dw_cfg = v & 'h1FF;
      REG_DST_HEIGHT: dh_cfg = v & 'h1FF;
      REG_STEP_X:     stx_cfg = v & 'hFFFFFF;
      REG_STEP_Y:     sty_cfg = v & 'hFFFFFF;
      REG_CHANNELS:   nch_cfg = v & 7;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || resampled_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pixel_req_t load_req(int x, int y);
    pixel_req_t r;
    r.act = 1'b0;
    r.x = 8'(x);
    r.y = 8'(y);
    r.c0 = 8'($urandom);
    r.c1 = 8'($urandom);
    r.c2 = 8'($urandom);
    r.c3 = 8'($urandom);
    return r;
  endfunction

  function automatic pixel_req_t compute_req(int x, int y);
    pixel_req_t r;
    r = pixel_req_t'({$urandom, $urandom});
    r.act = 1'b1;
    r.x = 8'(x);
    r.y = 8'(y);
    return r;
  endfunction

  task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                           int unsigned sx, int unsigned sy, int unsigned nch,
                           int idle, int stall, int nrand);
    int lw, lh;
    longint rx, ry;
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_CHANNELS, nch);
    send_idle = idle;
    recv_stall = stall;
    lw = sw > 256 ? 256 : sw;
    lh = sh > 256 ? 256 : sh;
    rx = ((longint'(dw - 1) * longint'(sx)) >> 16) + RADIUS + 1;
    ry = ((longint'(dh - 1) * longint'(sy)) >> 16) + RADIUS + 1;
    if (rx < lw) lw = int'(rx);
    if (ry < lh) lh = int'(ry);
    for (int y = 0; y < lh; y++)
      for (int x = 0; x < lw; x++)
        if (!written[y*256 + x]) begin
          pending_q.push_back(load_req(x, y));
          written[y*256 + x] = 1'b1;
        end
    pending_q.push_back(compute_req(0, 0));
    pending_q.push_back(compute_req(dw - 1, dh - 1));
    pending_q.push_back(compute_req(255, 255));
    for (int n = 0; n < nrand; n++) begin
      if ($urandom_range(99) < 45) begin
        pending_q.push_back(load_req($urandom_range(255), $urandom_range(255)));
      end else if ($urandom_range(99) < 80) begin
        pending_q.push_back(compute_req($urandom_range(dw - 1), $urandom_range(dh - 1)));
      end else begin
        pending_q.push_back(compute_req($urandom_range(255), $urandom_range(255)));
      end
    end
  endtask

  initial begin
    pixel_req_t r;
    for (int p = 0; p < 2*PHASES; p++) kern_lut[p] = kernel_q14(p);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_phase(8, 8, 16, 16, 32768, 32768, 4, 0, 0, 0);
    r = '{1'b0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00};
    pending_q.push_back(r);
    r = '{1'b0, 8'd7, 8'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    pending_q.push_back(r);
    r = '{1'b0, 8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF, 8'h00};
    pending_q.push_back(r);
    pending_q.push_back(compute_req(0, 0));
    pending_q.push_back(compute_req(15, 15));
    pending_q.push_back(compute_req(7, 3));
    pending_q.push_back(compute_req(16, 0));
    pending_q.push_back(compute_req(0, 16));
    for (int n = 0; n < 10; n++) pending_q.push_back(compute_req(2 * n + 1, n));

    run_phase(8, 8, 16, 16, 32768, 32768, 4, 0, 0, 20);
    run_phase(6, 5, 3, 3, 131072, 131072, 1, 71, 0, 25);
    run_phase(511, 1, 256, 4, 65536, 0, 3, 0, 71, 25);
    run_phase(1, 300, 2, 256, 16777215, 65536, 2, 7, 7, 25);
    run_phase(12, 10, 256, 256, 12345, 70000, 0, 71, 71, 20);
    run_phase(4, 4, 1, 1, 16777215, 16777215, 7, 0, 0, 15);
    holds_asked++;
    run_phase(16, 16, 20, 20, 52428, 52428, 4, 0, 0, 25);
    run_phase(511, 300, 8, 8, 65536, 65536, 4, 7, 7, 25);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("lanczos_image_scaler_tb: PASS");
    end else begin
      $display("lanczos_image_scaler_tb: FAIL");
    end
    $finish;
  end

endmodule
